### hw/rtl/multicast_tree_state_table_top_macros.svh
// Assertion macros used by the state table controller.
`ifndef MULTICAST_TREE_STATE_TABLE_TOP_MACROS_SVH
`define MULTICAST_TREE_STATE_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define MTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define MTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MTS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/mts_pkg.sv
// Package with shared types and codes of the multicast state table.
package mts_pkg;
	localparam int unsigned EntriesDefault = 16;

	localparam logic [2:0] FN_JOIN = 3'd0;
	localparam logic [2:0] FN_PRUNE = 3'd1;
	localparam logic [2:0] FN_REFRESH = 3'd2;
	localparam logic [2:0] FN_LJOIN = 3'd3;
	localparam logic [2:0] FN_LPRUNE = 3'd4;

	localparam logic [1:0] SEND_NONE = 2'd0;
	localparam logic [1:0] SEND_JOIN = 2'd1;
	localparam logic [1:0] SEND_PRUNE = 2'd2;

	localparam logic [2:0] ST_INC = 3'd0;
	localparam logic [2:0] ST_ADD = 3'd1;
	localparam logic [2:0] ST_DEC = 3'd2;
	localparam logic [2:0] ST_DEL = 3'd3;
	localparam logic [2:0] ST_REF = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;
	localparam logic [2:0] ST_NOROUTE = 3'd6;
	localparam logic [2:0] ST_NOTFOUND = 3'd7;

	localparam logic [63:0] LOCAL_PARENT_LO = 64'h1;

	typedef struct packed {
		logic [2:0] func;
		logic [63:0] source_hi;
		logic [63:0] source_lo;
		logic [63:0] group_hi;
		logic [63:0] group_lo;
		logic source_is_local;
		logic route_found;
		logic [63:0] hop_hi;
		logic [63:0] hop_lo;
		logic [31:0] now_time;
		logic listener_flag;
	} req_t;

	typedef struct packed {
		logic [1:0] send_kind;
		logic [63:0] dest_hi;
		logic [63:0] dest_lo;
		logic [2:0] status;
		logic [7:0] count_after;
	} rsp_t;

	// Stored entry payload, one memory word.
	typedef struct packed {
		logic [63:0] source_hi;
		logic [63:0] source_lo;
		logic [63:0] group_hi;
		logic [63:0] group_lo;
		logic [63:0] parent_hi;
		logic [63:0] parent_lo;
		logic [31:0] refresh;
		logic listener;
		logic [7:0] count;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic rd_req;
		logic wr_new;
		logic wr_refresh;
		logic cnt_inc;
		logic cnt_dec;
		logic clr_valid;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
		logic hit;
		logic free_found;
		logic count_gt1;
	} sts_t;
endpackage

### hw/rtl/mts_if.sv
// Valid/ready channel interface carrying one payload.
interface mts_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### hw/rtl/mts_ram.sv
// Generic single-port RAM with registered read.
module mts_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	// One write and one read of the same address per cycle; the read returns the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

### hw/rtl/mts_datapath.sv
// Datapath: entry memory, valid bits, counts, scan pointer and request register.
module mts_datapath #(
	parameter int unsigned Entries = 16
) (
	input logic clk,
	input logic arst_n,
	input mts_pkg::req_t req,
	input mts_pkg::cmd_t cmd,
	output mts_pkg::sts_t sts,
	output mts_pkg::req_t req_q,
	output logic [7:0] count_q
);
	import mts_pkg::*;
	localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;

	logic [Entries-1:0] valid_q;
	logic [IdxW-1:0] ptr_q;
	logic [IdxW-1:0] hit_idx_q;
	logic [IdxW-1:0] free_idx_q;
	logic hit_q;
	logic free_q;
	logic rd_pend_q;
	logic done_q;
	logic [IdxW-1:0] rd_idx_q;
	logic ram_we;
	logic [IdxW-1:0] ram_addr;
	entry_t ram_wdata;
	entry_t ram_rdata;
	logic key_eq;

	// Payload is captured when a transaction is accepted.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	assign key_eq = (ram_rdata.source_hi == req_q.source_hi)
		&& (ram_rdata.source_lo == req_q.source_lo)
		&& (ram_rdata.group_hi == req_q.group_hi)
		&& (ram_rdata.group_lo == req_q.group_lo);

	// Memory address: the scan pointer while searching, the hit or free slot on update.
	// The hit entry is read back once the search ends, so updates modify its own word.
	always_comb begin
		ram_we = cmd.wr_new || cmd.wr_refresh || cmd.cnt_inc || cmd.cnt_dec;
		ram_addr = ptr_q;
		ram_wdata = ram_rdata;
		if (cmd.wr_new) begin
			ram_addr = free_idx_q;
			ram_wdata.source_hi = req_q.source_hi;
			ram_wdata.source_lo = req_q.source_lo;
			ram_wdata.group_hi = req_q.group_hi;
			ram_wdata.group_lo = req_q.group_lo;
			ram_wdata.parent_hi = (req_q.source_is_local && req_q.func != FN_LJOIN)
				? 64'd0 : req_q.hop_hi;
			ram_wdata.parent_lo = (req_q.source_is_local && req_q.func != FN_LJOIN)
				? LOCAL_PARENT_LO : req_q.hop_lo;
			ram_wdata.refresh = req_q.now_time;
			ram_wdata.listener = (req_q.func == FN_LJOIN) ? req_q.listener_flag : 1'b0;
			ram_wdata.count = 8'd1;
		end else if (cmd.wr_refresh) begin
			ram_addr = hit_idx_q;
			ram_wdata.refresh = req_q.now_time;
		end else if (cmd.cnt_inc) begin
			ram_addr = hit_idx_q;
			ram_wdata.count = (ram_rdata.count != 8'hFF)
				? ram_rdata.count + 8'd1 : ram_rdata.count;
		end else if (cmd.cnt_dec) begin
			ram_addr = hit_idx_q;
			ram_wdata.count = ram_rdata.count - 8'd1;
		end else if (cmd.rd_req) begin
			ram_addr = hit_idx_q;
		end
	end

	mts_ram #(.Width($bits(entry_t)), .Depth(Entries)) u_ram (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Serial search: one entry read per cycle, compared the cycle after.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			rd_pend_q <= 1'b0;
			done_q <= 1'b0;
			rd_idx_q <= '0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
		end else begin
			if (cmd.scan_start) begin
				ptr_q <= '0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
				rd_pend_q <= 1'b0;
				done_q <= 1'b0;
			end else if (cmd.scan_step && !done_q) begin
				if (rd_pend_q) begin
					if (valid_q[rd_idx_q] && key_eq && !hit_q) begin
						hit_q <= 1'b1;
						hit_idx_q <= rd_idx_q;
					end
					if (!valid_q[rd_idx_q] && !free_q) begin
						free_q <= 1'b1;
						free_idx_q <= rd_idx_q;
					end
					if (32'(rd_idx_q) == Entries - 1) begin
						done_q <= 1'b1;
					end
				end
				rd_pend_q <= 1'b1;
				rd_idx_q <= ptr_q;
				if (32'(ptr_q) != Entries - 1) begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
		end
	end

	// Valid bits, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr_new) begin
			valid_q[free_idx_q] <= 1'b1;
		end else if (cmd.clr_valid) begin
			valid_q[hit_idx_q] <= 1'b0;
		end
	end

	// Join count of the entry as written by the update.
	always_ff @(posedge clk) begin
		if (ram_we) begin
			count_q <= ram_wdata.count;
		end
	end

	assign sts.scan_done = done_q;
	assign sts.hit = hit_q;
	assign sts.free_found = free_q;
	assign sts.count_gt1 = ram_rdata.count > 8'd1;
endmodule

### hw/rtl/mts_ctrl.sv
// Controller: sequences search, decision, update and result hand-off.
module mts_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input mts_pkg::req_t req_q,
	input mts_pkg::sts_t sts,
	input logic [7:0] count_q,
	output mts_pkg::cmd_t cmd,
	output mts_pkg::rsp_t rsp_q
);
	import mts_pkg::*;
	`include "multicast_tree_state_table_top_macros.svh"

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_REPORT = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [2:0] stat_q;
	logic [2:0] stat_d;
	logic [1:0] kind_q;
	logic [1:0] kind_d;
	logic zero_cnt_q;
	logic zero_cnt_d;
	logic join_like;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// State sequencing and commands, with the decision on the search result.
	always_comb begin
		cmd = '0;
		state_d = state_q;
		stat_d = stat_q;
		kind_d = kind_q;
		zero_cnt_d = zero_cnt_q;
		join_like = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.scan_start = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					// Read back the hit entry for the update.
					cmd.rd_req = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_REPORT;
				kind_d = SEND_NONE;
				zero_cnt_d = 1'b1;
				case (req_q.func)
					FN_JOIN, FN_REFRESH: begin
						if (sts.hit && req_q.func == FN_REFRESH) begin
							cmd.wr_refresh = 1'b1;
							stat_d = ST_REF;
							zero_cnt_d = 1'b0;
						end else begin
							join_like = 1'b1;
						end
					end
					FN_LJOIN: begin
						if (!req_q.route_found) begin
							stat_d = ST_NOROUTE;
						end else begin
							join_like = 1'b1;
						end
					end
					FN_PRUNE, FN_LPRUNE: begin
						if (req_q.func == FN_LPRUNE && !req_q.route_found) begin
							stat_d = ST_NOROUTE;
						end else if (!sts.hit) begin
							stat_d = ST_NOTFOUND;
						end else if (sts.count_gt1) begin
							cmd.cnt_dec = 1'b1;
							stat_d = ST_DEC;
							zero_cnt_d = 1'b0;
						end else begin
							cmd.clr_valid = 1'b1;
							stat_d = ST_DEL;
							kind_d = req_q.route_found ? SEND_PRUNE : SEND_NONE;
						end
					end
					default: begin
						stat_d = ST_NOTFOUND;
					end
				endcase
				if (join_like) begin
					if (sts.hit) begin
						cmd.cnt_inc = 1'b1;
						stat_d = ST_INC;
						zero_cnt_d = 1'b0;
					end else if (req_q.source_is_local && req_q.func != FN_LJOIN) begin
						if (sts.free_found) begin
							cmd.wr_new = 1'b1;
							stat_d = ST_ADD;
							zero_cnt_d = 1'b0;
						end else begin
							stat_d = ST_FULL;
						end
					end else if (!req_q.route_found) begin
						stat_d = ST_NOROUTE;
					end else if (sts.free_found) begin
						cmd.wr_new = 1'b1;
						stat_d = ST_ADD;
						kind_d = SEND_JOIN;
						zero_cnt_d = 1'b0;
					end else begin
						stat_d = ST_FULL;
					end
				end
			end
			S_REPORT: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stat_q <= ST_NOTFOUND;
			kind_q <= SEND_NONE;
			zero_cnt_q <= 1'b1;
		end else begin
			state_q <= state_d;
			stat_q <= stat_d;
			kind_q <= kind_d;
			zero_cnt_q <= zero_cnt_d;
		end
	end

	// Result register, built once the table update has landed.
	always_ff @(posedge clk) begin
		if (state_q == S_REPORT) begin
			rsp_q.send_kind <= kind_q;
			rsp_q.dest_hi <= (kind_q != SEND_NONE) ? req_q.hop_hi : 64'd0;
			rsp_q.dest_lo <= (kind_q != SEND_NONE) ? req_q.hop_lo : 64'd0;
			rsp_q.status <= stat_q;
			rsp_q.count_after <= zero_cnt_q ? 8'd0 : count_q;
		end
	end

	`MTS_ASSERT_IMP(a_one_role, clk, arst_n, 1'b1, !(in_ready && out_valid))
	`MTS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`MTS_ASSERT_IMP(a_no_dbl_write, clk, arst_n, 1'b1, !(cmd.wr_new && cmd.wr_refresh))
	`MTS_ASSERT_IMP(a_add_zero_send, clk, arst_n,
		out_valid && rsp_q.send_kind == SEND_NONE, rsp_q.dest_hi == 64'd0)
endmodule

### hw/rtl/multicast_tree_state_table_top.sv
// Top level of the multicast source-group join/prune state table.
// Input channel "req" carries one control operation per transaction; output
// channel "rsp" returns exactly one result transaction for each.
// An operation runs a serial search over the table, one entry read from the
// entry memory per cycle across every entry, then the decide and report states
// build the result, which the receiver may then hold off.
// The memory read port, walked once per search, sets the search time. One
// operation is in flight at a time: req is ready only when the block is idle,
// so a new operation is taken only after the last result is delivered.
// The result is held in an output register while rsp_ready is low; no new
// operation is taken until it is delivered.
// Reset clears all valid bits at once, so the table is empty right after
// reset with no clearing pass; entry contents are don't-care until written.
module multicast_tree_state_table_top #(
	parameter int unsigned ENTRIES = mts_pkg::EntriesDefault
) (
	input logic clk,
	input logic arst_n,
	mts_if.sink req,
	mts_if.source rsp
);
	import mts_pkg::*;

	cmd_t cmd;
	sts_t sts;
	req_t req_q;
	logic [7:0] count_q;
	rsp_t rsp_q;

	mts_datapath #(.Entries(ENTRIES)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.payload),
		.cmd(cmd),
		.sts(sts),
		.req_q(req_q),
		.count_q(count_q)
	);

	mts_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.req_q(req_q),
		.sts(sts),
		.count_q(count_q),
		.cmd(cmd),
		.rsp_q(rsp_q)
	);

	assign rsp.payload = rsp_q;
endmodule
